// File: rtl/cc20_pkg.sv
// Shared types, constants and the state-setup function for the ChaCha20 stream block.
// Used by cc20_core and chacha20_stream_xor; depends on nothing else.
`default_nettype none

package cc20_pkg;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned BLOCK_BYTES   = 64;

  // register indexes of the configuration port (byte address = 8 * index)
  localparam logic [2:0] REG_KEY0     = 3'd0;
  localparam logic [2:0] REG_KEY1     = 3'd1;
  localparam logic [2:0] REG_KEY2     = 3'd2;
  localparam logic [2:0] REG_KEY3     = 3'd3;
  localparam logic [2:0] REG_NONCE_LO = 3'd4;
  localparam logic [2:0] REG_NONCE_HI = 3'd5;
  localparam logic [2:0] REG_INIT_CTR = 3'd6;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce_low;
    logic [31:0]      nonce_high;
  } cc20_cfg_t;

  typedef struct packed {
    logic start;
  } cc20_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cc20_stat_t;

  // word idx of the block input state
  function automatic logic [31:0] cc20_init_word(logic [3:0] idx, cc20_cfg_t cfg,
                                                 logic [31:0] ctr);
    logic [31:0] r;
    unique case (idx)
      4'd0:  r = SIGMA0;
      4'd1:  r = SIGMA1;
      4'd2:  r = SIGMA2;
      4'd3:  r = SIGMA3;
      4'd4:  r = cfg.key[0][31:0];
      4'd5:  r = cfg.key[0][63:32];
      4'd6:  r = cfg.key[1][31:0];
      4'd7:  r = cfg.key[1][63:32];
      4'd8:  r = cfg.key[2][31:0];
      4'd9:  r = cfg.key[2][63:32];
      4'd10: r = cfg.key[3][31:0];
      4'd11: r = cfg.key[3][63:32];
      4'd12: r = ctr;
      4'd13: r = cfg.nonce_low[31:0];
      4'd14: r = cfg.nonce_low[63:32];
      4'd15: r = cfg.nonce_high;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cc20_core.sv
// ChaCha20 block engine: one shared add-xor-rotate unit stepped by a small sequencer.
// Depends on cc20_pkg for the config struct, control/status structs and state setup.
`default_nettype none

module cc20_core import cc20_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cc20_ctrl_t  ctrl,
  input  wire cc20_cfg_t   cfg,
  input  wire logic [31:0] counter,
  input  wire logic [3:0]  rd_word,
  output logic [31:0]      rd_data,
  output cc20_stat_t       stat
);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FINAL} cstate_t;

  localparam logic [3:0] LAST_DR = 4'(DOUBLE_ROUNDS - 1);

  cstate_t     state;
  logic [1:0]  sub;    // step within a quarter round
  logic [2:0]  qcnt;   // quarter round within a double round
  logic [3:0]  dcnt;   // double round
  logic [3:0]  fcnt;   // word of the final add
  logic        done;

  // working words; they hold the keystream block once a block is finished
  logic [31:0] w      [16];
  logic [31:0] w_upd  [16];
  logic [31:0] w_next [16];

  logic [31:0] op_x, op_y, op_z, sum, mix_in, mixed;
  logic [1:0]  row_shift [4];

  // shared unit: a fixed column a,b,c,d = w[0], w[4], w[8], w[12]
  always_comb begin
    if (state == C_FINAL) begin
      op_x = w[0];
      op_y = cc20_init_word(fcnt, cfg, counter);
      op_z = w[12];
    end else if (!sub[0]) begin
      op_x = w[0];
      op_y = w[4];
      op_z = w[12];
    end else begin
      op_x = w[8];
      op_y = w[12];
      op_z = w[4];
    end
    sum    = op_x + op_y;
    mix_in = op_z ^ sum;
    unique case (sub)
      2'd0: mixed = {mix_in[15:0], mix_in[31:16]};
      2'd1: mixed = {mix_in[19:0], mix_in[31:20]};
      2'd2: mixed = {mix_in[23:0], mix_in[31:24]};
      2'd3: mixed = {mix_in[24:0], mix_in[31:25]};
      default: mixed = mix_in;
    endcase
  end

  // row rotation after each quarter round: next column, and (un)diagonalize at half turns
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      if (qcnt == 3'd3) begin
        row_shift[r] = 2'd1 + 2'(r);
      end else if (qcnt == 3'd7) begin
        row_shift[r] = 2'd1 - 2'(r);
      end else begin
        row_shift[r] = 2'd1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      w_upd[i] = w[i];
    end
    if (!sub[0]) begin
      w_upd[0]  = sum;
      w_upd[12] = mixed;
    end else begin
      w_upd[8]  = sum;
      w_upd[4]  = mixed;
    end

    for (int i = 0; i < 16; i++) begin
      w_next[i] = w[i];
    end
    unique case (state)
      C_IDLE: begin
        if (ctrl.start) begin
          for (int i = 0; i < 16; i++) begin
            w_next[i] = cc20_init_word(4'(i), cfg, counter);
          end
        end
      end
      C_ROUND: begin
        if (sub == 2'd3) begin
          for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
              w_next[r*4 + j] = w_upd[{2'(r), 2'(j) + row_shift[r]}];
            end
          end
        end else begin
          for (int i = 0; i < 16; i++) begin
            w_next[i] = w_upd[i];
          end
        end
      end
      C_FINAL: begin
        // rotate the whole block through the adder; order is restored after 16 steps
        for (int i = 0; i < 15; i++) begin
          w_next[i] = w[i + 1];
        end
        w_next[15] = sum;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      w[i] <= w_next[i];
    end
    if (rst) begin
      state <= C_IDLE;
      sub   <= '0;
      qcnt  <= '0;
      dcnt  <= '0;
      fcnt  <= '0;
      done  <= 1'b0;
    end else begin
      // pulse for one cycle after the last word of the final add
      done <= (state == C_FINAL) && (fcnt == 4'd15);
      unique case (state)
        C_IDLE: begin
          if (ctrl.start) begin
            state <= C_ROUND;
            sub   <= '0;
            qcnt  <= '0;
            dcnt  <= '0;
          end
        end
        C_ROUND: begin
          sub <= sub + 2'd1;
          if (sub == 2'd3) begin
            qcnt <= qcnt + 3'd1;
            if (qcnt == 3'd7) begin
              dcnt <= dcnt + 4'd1;
              if (dcnt == LAST_DR) begin
                state <= C_FINAL;
                fcnt  <= '0;
              end
            end
          end
        end
        C_FINAL: begin
          fcnt <= fcnt + 4'd1;
          if (fcnt == 4'd15) begin
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  assign rd_data   = w[rd_word];
  assign stat.busy = (state != C_IDLE);
  assign stat.done = done;

endmodule

`default_nettype wire

// File: rtl/chacha20_stream_xor.sv
// Top level of the ChaCha20 (IETF, 96-bit nonce) byte stream XOR block.
// Depends on cc20_pkg and cc20_core; holds the APB registers and the byte stream control.
`default_nettype none

// ChaCha20 stream XOR, one byte per request. Each input byte on s_tdata leaves on
// m_tdata XORed with the next keystream byte; s_tlast travels to m_tlast unchanged.
// s_tuser marks the first byte of a message: the block counter reloads from
// initial_counter and keystream starts at byte 0 of a fresh block. Without a start
// after reset the stream begins at counter 0. Rate: a byte whose keystream block is
// already in hand goes out at one byte per cycle while the output register is kept
// free. A byte that needs a new block (the first after a start, and every 64th) waits
// while the core is started, runs 80 quarter rounds of four steps (one add, xor and
// rotate of the single shared 32-bit unit per cycle), adds the initial state back
// through the same adder word by word, and hands the result over. Input is not
// taken while a block is computed. The key, nonce and counter registers sit on a
// 64-bit APB port at byte address 8 * index; write them only while the stream is idle.
// They take effect at the next block.
module chacha20_stream_xor import cc20_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // stream in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_in
  input  wire logic        s_tuser,   // [0] message_start
  input  wire logic        s_tlast,   // message_end
  // stream out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] data_out
  output logic             m_tlast,   // end_flag
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_KICK, ST_WAIT} state_t;

  localparam logic [5:0] LAST_BYTE = 6'(BLOCK_BYTES - 1);

  state_t      state;
  cc20_cfg_t   cfg;
  logic [31:0] initial_counter;
  logic [31:0] block_counter;
  logic [5:0]  byte_position;
  logic        keystream_ready;
  logic [7:0]  data_hold;
  logic        last_hold;

  cc20_ctrl_t  ctrl;
  cc20_stat_t  stat;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;
  logic [5:0]  rd_pos;
  logic        accept;
  logic        cfg_wr;
  logic [2:0]  reg_idx;
  logic        out_free;
  logic [7:0]  emit_data;
  logic        emit_last;
  logic        emit;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[5:3];

  // register file writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg             <= '0;
      initial_counter <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_KEY0:     cfg.key[0]     <= pwdata;
        REG_KEY1:     cfg.key[1]     <= pwdata;
        REG_KEY2:     cfg.key[2]     <= pwdata;
        REG_KEY3:     cfg.key[3]     <= pwdata;
        REG_NONCE_LO: cfg.nonce_low  <= pwdata;
        REG_NONCE_HI: cfg.nonce_high <= pwdata[31:0];
        REG_INIT_CTR: initial_counter <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY0:     prdata = cfg.key[0];
      REG_KEY1:     prdata = cfg.key[1];
      REG_KEY2:     prdata = cfg.key[2];
      REG_KEY3:     prdata = cfg.key[3];
      REG_NONCE_LO: prdata = cfg.nonce_low;
      REG_NONCE_HI: prdata = {32'd0, cfg.nonce_high};
      REG_INIT_CTR: prdata = {32'd0, initial_counter};
      default:      prdata = '0;
    endcase
  end

  // take a request only when idle and the output register is free next cycle
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  // a start flag reads keystream from byte 0 of the new block
  assign rd_pos = (state == ST_IDLE && s_tuser) ? 6'd0 : byte_position;

  always_comb begin
    unique case (rd_pos[1:0])
      2'd0: ks_byte = ks_word[7:0];
      2'd1: ks_byte = ks_word[15:8];
      2'd2: ks_byte = ks_word[23:16];
      2'd3: ks_byte = ks_word[31:24];
      default: ks_byte = ks_word[7:0];
    endcase
  end

  assign emit_data = (state == ST_IDLE) ? s_tdata : data_hold;
  assign emit_last = (state == ST_IDLE) ? s_tlast : last_hold;

  // a result lands either straight from an accepted byte or when a new block is done
  assign emit = ((state == ST_IDLE) && accept && !s_tuser && keystream_ready) ||
                ((state == ST_WAIT) && stat.done);

  assign ctrl.start = (state == ST_KICK);

  cc20_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .cfg     (cfg),
    .counter (block_counter),
    .rd_word (rd_pos[5:2]),
    .rd_data (ks_word),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      block_counter   <= '0;
      byte_position   <= '0;
      keystream_ready <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      // raise valid for a new result, else drop it once taken
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            data_hold <= s_tdata;
            last_hold <= s_tlast;
            if (s_tuser) begin
              block_counter <= initial_counter;
              byte_position <= '0;
            end
            if (s_tuser || !keystream_ready) begin
              keystream_ready <= 1'b0;
              state           <= ST_KICK;
            end else begin
              m_tdata         <= emit_data ^ ks_byte;
              m_tlast         <= emit_last;
              byte_position   <= rd_pos + 6'd1;
              keystream_ready <= (rd_pos != LAST_BYTE);
            end
          end
        end
        ST_KICK: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          // block ready: advance the counter and hand over the held byte
          if (stat.done) begin
            block_counter   <= block_counter + 32'd1;
            m_tdata         <= emit_data ^ ks_byte;
            m_tlast         <= emit_last;
            byte_position   <= rd_pos + 6'd1;
            keystream_ready <= (rd_pos != LAST_BYTE);
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !stat.busy)
    else $error("input accepted while a block is computed");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (state == ST_WAIT))
    else $error("block finished outside the wait state");

  a_start_new_block: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=> (state == ST_KICK) && (byte_position == 6'd0))
    else $error("message start did not begin a new block");
`endif

endmodule

`default_nettype wire
